// ===== rtl/sbl_pkg.sv =====
// Shared types, register indexes and blur arithmetic for the separable 5x5 blur.
package sbl_pkg;

    localparam int CFG_INDEX_W       = 2;
    localparam int CFG_DATA_W        = 12;
    localparam int IMAGE_WIDTH_BITS  = 11;
    localparam int IMAGE_HEIGHT_BITS = 12;
    localparam int IMAGE_WIDTH_RST   = 640;
    localparam int IMAGE_HEIGHT_RST  = 480;
    localparam int LINE_TAPS         = 4;

    localparam logic [CFG_INDEX_W-1:0] REG_IMAGE_WIDTH  = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_IMAGE_HEIGHT = 2'd1;

    localparam logic ACTION_PIXEL = 1'b0;

    localparam logic [12:0] DIV10_RECIP = 13'd6554;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } pixel_t;

    typedef struct packed {
        logic hvalid;
        logic emit;
        logic h_edge;
        logic v_edge;
        logic last;
    } stage_ctrl_t;

    // Exact for every sum a five-tap 1-2-4-2-1 window of bytes can produce.
    function automatic logic [7:0] div10(input logic [11:0] x);
        logic [24:0] prod;
        prod = 25'(x) * 25'(DIV10_RECIP);
        return prod[23:16];
    endfunction

    function automatic logic [7:0] blur_chan(input logic [7:0] a, input logic [7:0] b,
                                             input logic [7:0] c, input logic [7:0] d,
                                             input logic [7:0] e);
        logic [11:0] sum;
        sum = 12'(a) + (12'(b) << 1) + (12'(c) << 2) + (12'(d) << 1) + 12'(e);
        return div10(sum);
    endfunction

    function automatic pixel_t blur_pix(input pixel_t a, input pixel_t b, input pixel_t c,
                                        input pixel_t d, input pixel_t e);
        pixel_t res;
        res.red   = blur_chan(a.red, b.red, c.red, d.red, e.red);
        res.green = blur_chan(a.green, b.green, c.green, d.green, e.green);
        res.blue  = blur_chan(a.blue, b.blue, c.blue, d.blue, e.blue);
        return res;
    endfunction

endpackage

// ===== rtl/sbl_if.sv =====
// Handshake interfaces for the pixel input, pixel output and configuration channels.
interface sbl_pix_in_if ();
    logic       valid;
    logic       ready;
    logic       action;
    logic [7:0] blue_in;
    logic [7:0] green_in;
    logic [7:0] red_in;

    modport source (output valid, action, blue_in, green_in, red_in, input ready);
    modport sink (input valid, action, blue_in, green_in, red_in, output ready);
endinterface

interface sbl_pix_out_if ();
    logic       valid;
    logic       ready;
    logic [7:0] blue_out;
    logic [7:0] green_out;
    logic [7:0] red_out;
    logic       frame_end;

    modport source (output valid, blue_out, green_out, red_out, frame_end, input ready);
    modport sink (input valid, blue_out, green_out, red_out, frame_end, output ready);
endinterface

interface sbl_cfg_if import sbl_pkg::*; ();
    logic                   valid;
    logic                   ready;
    logic [CFG_INDEX_W-1:0] index;
    logic [CFG_DATA_W-1:0]  data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

// ===== rtl/separable_blur_5x5_rgb_core.sv =====
// Top level of the streaming separable 5x5 blur over 8-bit RGB pixels.
// One transaction per cycle while the output is not stalled; each passes the stage-one,
// stage-two and output registers. Output k rides on input transaction k + 2*width + 2.
// The line store has one read port and one write port, one column of four lines per cycle.
// Reset clears all counters and sets the size to 640 by 480; the line store is not cleared.
module separable_blur_5x5_rgb_core import sbl_pkg::*; #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 2048
) (
    input  logic          clk,
    input  logic          rst_n,
    sbl_pix_in_if.sink    pix_in,
    sbl_pix_out_if.source pix_out,
    sbl_cfg_if.sink       cfg
);

    localparam int CW = $clog2(MAX_WIDTH);

    logic          en;
    logic          in_acc;
    logic          cfg_wr;
    logic          win_shift;
    logic          out_valid;
    logic          out_last;
    pixel_t        in_pix;
    pixel_t        s2_hval;
    pixel_t        out_pix;
    stage_ctrl_t   s1_ctrl;
    stage_ctrl_t   s2_ctrl;
    logic [CW-1:0] s1_col;

    assign en           = !out_valid || pix_out.ready;
    assign pix_in.ready = en;
    assign cfg.ready    = 1'b1;
    assign in_acc       = pix_in.valid && en;
    assign cfg_wr       = cfg.valid;

    assign in_pix.red   = pix_in.red_in;
    assign in_pix.green = pix_in.green_in;
    assign in_pix.blue  = pix_in.blue_in;

    sbl_ctrl #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .en          (en),
        .in_acc      (in_acc),
        .action      (pix_in.action),
        .cfg_wr      (cfg_wr),
        .cfg_index   (cfg.index),
        .cfg_data    (cfg.data),
        .win_shift   (win_shift),
        .s1_ctrl_reg (s1_ctrl),
        .s1_col_reg  (s1_col)
    );

    sbl_hpass u_hpass (
        .clk         (clk),
        .rst_n       (rst_n),
        .en          (en),
        .win_shift   (win_shift),
        .in_pix      (in_pix),
        .s1_ctrl     (s1_ctrl),
        .s2_ctrl_reg (s2_ctrl),
        .s2_hval_reg (s2_hval)
    );

    sbl_vpass #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_vpass (
        .clk           (clk),
        .rst_n         (rst_n),
        .en            (en),
        .s1_hvalid     (s1_ctrl.hvalid),
        .s1_col        (s1_col),
        .s2_ctrl       (s2_ctrl),
        .s2_hval       (s2_hval),
        .out_valid_reg (out_valid),
        .out_pix_reg   (out_pix),
        .out_last_reg  (out_last)
    );

    assign pix_out.valid     = out_valid;
    assign pix_out.blue_out  = out_pix.blue;
    assign pix_out.green_out = out_pix.green;
    assign pix_out.red_out   = out_pix.red;
    assign pix_out.frame_end = out_last;

endmodule

// ===== rtl/sbl_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module sbl_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data_reg
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

endmodule

// ===== rtl/sbl_ctrl.sv =====
// Frame geometry registers, position counters and per-transaction stage control.
module sbl_ctrl import sbl_pkg::*; #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 2048
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         en,
    input  logic                         in_acc,
    input  logic                         action,
    input  logic                         cfg_wr,
    input  logic [CFG_INDEX_W-1:0]       cfg_index,
    input  logic [CFG_DATA_W-1:0]        cfg_data,
    output logic                         win_shift,
    output stage_ctrl_t                  s1_ctrl_reg,
    output logic [$clog2(MAX_WIDTH)-1:0] s1_col_reg
);

    localparam int CW    = $clog2(MAX_WIDTH);
    localparam int WW    = $clog2(MAX_WIDTH + 1);
    localparam int RW    = $clog2(MAX_HEIGHT);
    localparam int HW    = $clog2(MAX_HEIGHT + 1);
    localparam int HRW   = $clog2(MAX_HEIGHT + 2);
    localparam int LW    = $clog2(2 * MAX_WIDTH + 3);
    localparam int W_RST = (IMAGE_WIDTH_RST > MAX_WIDTH) ? MAX_WIDTH : IMAGE_WIDTH_RST;
    localparam int H_RST = (IMAGE_HEIGHT_RST > MAX_HEIGHT) ? MAX_HEIGHT : IMAGE_HEIGHT_RST;

    logic [WW-1:0]  w_reg, w_next;
    logic [CW-1:0]  wm1_reg, wm1_next;
    logic [LW-1:0]  lead_max_reg, lead_max_next;
    logic [HW-1:0]  h_reg, h_next;
    logic [RW-1:0]  hm1_reg, hm1_next;
    logic [HRW-1:0] hp1_reg, hp1_next;

    logic [CW-1:0]  icol_reg, icol_next;
    logic [RW-1:0]  irow_reg, irow_next;
    logic           in_done_reg, in_done_next;
    logic [LW-1:0]  lead_reg, lead_next;
    logic [CW-1:0]  hcol_reg, hcol_next;
    logic [HRW-1:0] hrow_reg, hrow_next;

    logic [IMAGE_WIDTH_BITS-1:0]  w_raw;
    logic [IMAGE_HEIGHT_BITS-1:0] h_raw;
    logic [WW-1:0]                w_new;
    logic [HW-1:0]                h_new;
    logic                         cfg_w_hit, cfg_h_hit;
    logic                         counted, do_acc, hvalid, emit, h_edge, v_edge, last;
    logic                         frame_done, restart;
    stage_ctrl_t                  stage_ctrl;

    assign w_raw     = cfg_data[IMAGE_WIDTH_BITS-1:0];
    assign h_raw     = cfg_data[IMAGE_HEIGHT_BITS-1:0];
    assign cfg_w_hit = cfg_wr && (cfg_index == REG_IMAGE_WIDTH);
    assign cfg_h_hit = cfg_wr && (cfg_index == REG_IMAGE_HEIGHT);

    // A drain request before the frame has fully arrived is dropped.
    assign counted    = in_done_reg || (action == ACTION_PIXEL);
    assign do_acc     = in_acc && counted;
    assign hvalid     = lead_reg >= LW'(2);
    assign emit       = lead_reg == lead_max_reg;
    assign h_edge     = (hcol_reg < CW'(2)) ||
                        ((WW + 1)'(hcol_reg) + (WW + 1)'(2) >= (WW + 1)'(w_reg));
    assign v_edge     = (hrow_reg < HRW'(4)) || (hrow_reg >= HRW'(h_reg));
    assign last       = (hrow_reg == hp1_reg) && (hcol_reg == wm1_reg);
    assign frame_done = do_acc && emit && last;
    assign restart    = cfg_w_hit || cfg_h_hit || frame_done;
    assign win_shift  = do_acc;

    always_comb
    begin
        if (w_raw == '0)
        begin
            w_new = WW'(1);
        end
        else if (32'(w_raw) > MAX_WIDTH)
        begin
            w_new = WW'(MAX_WIDTH);
        end
        else
        begin
            w_new = WW'(w_raw);
        end

        if (h_raw == '0)
        begin
            h_new = HW'(1);
        end
        else if (32'(h_raw) > MAX_HEIGHT)
        begin
            h_new = HW'(MAX_HEIGHT);
        end
        else
        begin
            h_new = HW'(h_raw);
        end
    end

    always_comb
    begin
        w_next        = w_reg;
        wm1_next      = wm1_reg;
        lead_max_next = lead_max_reg;
        h_next        = h_reg;
        hm1_next      = hm1_reg;
        hp1_next      = hp1_reg;
        icol_next     = icol_reg;
        irow_next     = irow_reg;
        in_done_next  = in_done_reg;
        lead_next     = lead_reg;
        hcol_next     = hcol_reg;
        hrow_next     = hrow_reg;

        if (cfg_w_hit)
        begin
            w_next        = w_new;
            wm1_next      = CW'(w_new - WW'(1));
            lead_max_next = LW'({w_new, 1'b0}) + LW'(2);
        end
        if (cfg_h_hit)
        begin
            h_next   = h_new;
            hm1_next = RW'(h_new - HW'(1));
            hp1_next = HRW'(h_new) + HRW'(1);
        end

        if (restart)
        begin
            icol_next    = '0;
            irow_next    = '0;
            in_done_next = 1'b0;
            lead_next    = '0;
            hcol_next    = '0;
            hrow_next    = '0;
        end
        else if (do_acc)
        begin
            if (!in_done_reg)
            begin
                if (icol_reg == wm1_reg)
                begin
                    icol_next = '0;
                    if (irow_reg == hm1_reg)
                    begin
                        irow_next    = '0;
                        in_done_next = 1'b1;
                    end
                    else
                    begin
                        irow_next = irow_reg + RW'(1);
                    end
                end
                else
                begin
                    icol_next = icol_reg + CW'(1);
                end
            end
            if (!emit)
            begin
                lead_next = lead_reg + LW'(1);
            end
            if (hvalid)
            begin
                if (hcol_reg == wm1_reg)
                begin
                    hcol_next = '0;
                    hrow_next = hrow_reg + HRW'(1);
                end
                else
                begin
                    hcol_next = hcol_reg + CW'(1);
                end
            end
        end
    end

    always_comb
    begin
        stage_ctrl = '0;
        if (do_acc)
        begin
            stage_ctrl.hvalid = hvalid;
            stage_ctrl.emit   = emit;
            stage_ctrl.h_edge = h_edge;
            stage_ctrl.v_edge = v_edge;
            stage_ctrl.last   = last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            w_reg        <= WW'(W_RST);
            wm1_reg      <= CW'(W_RST - 1);
            lead_max_reg <= LW'(2 * W_RST + 2);
            h_reg        <= HW'(H_RST);
            hm1_reg      <= RW'(H_RST - 1);
            hp1_reg      <= HRW'(H_RST + 1);
            icol_reg     <= '0;
            irow_reg     <= '0;
            in_done_reg  <= 1'b0;
            lead_reg     <= '0;
            hcol_reg     <= '0;
            hrow_reg     <= '0;
            s1_ctrl_reg  <= '0;
        end
        else
        begin
            w_reg        <= w_next;
            wm1_reg      <= wm1_next;
            lead_max_reg <= lead_max_next;
            h_reg        <= h_next;
            hm1_reg      <= hm1_next;
            hp1_reg      <= hp1_next;
            icol_reg     <= icol_next;
            irow_reg     <= irow_next;
            in_done_reg  <= in_done_next;
            lead_reg     <= lead_next;
            hcol_reg     <= hcol_next;
            hrow_reg     <= hrow_next;
            if (en)
            begin
                s1_ctrl_reg <= stage_ctrl;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_col_reg <= hcol_reg;
        end
    end

`ifndef SYNTHESIS
    a_lead_bound: assert property (@(posedge clk) disable iff (!rst_n)
        lead_reg <= lead_max_reg)
        else $error("Fill count ran past its limit.");

    a_col_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (hcol_reg <= wm1_reg) && (icol_reg <= wm1_reg))
        else $error("Column counter left the active row.");

    a_last_after_input: assert property (@(posedge clk) disable iff (!rst_n)
        frame_done |-> in_done_reg)
        else $error("Frame end issued before the whole frame arrived.");

    a_frame_restart: assert property (@(posedge clk) disable iff (!rst_n)
        frame_done |=> (lead_reg == '0) && !in_done_reg && (hrow_reg == '0))
        else $error("Counters not cleared after frame end.");

    a_emit_has_column: assert property (@(posedge clk) disable iff (!rst_n)
        s1_ctrl_reg.emit |-> s1_ctrl_reg.hvalid)
        else $error("Output requested without a row-filtered value.");
`endif

endmodule

// ===== rtl/sbl_hpass.sv =====
// Five-pixel window and the horizontal 1-2-4-2-1 filter stage.
module sbl_hpass import sbl_pkg::*; (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        en,
    input  logic        win_shift,
    input  pixel_t      in_pix,
    input  stage_ctrl_t s1_ctrl,
    output stage_ctrl_t s2_ctrl_reg,
    output pixel_t      s2_hval_reg
);

    pixel_t win_reg [5];
    pixel_t hval;

    // The window center is two transactions old; its neighbors share its row
    // unless the center sits in the first two or the last two columns of the row.
    assign hval = s1_ctrl.h_edge ? win_reg[2]
                                 : blur_pix(win_reg[4], win_reg[3], win_reg[2],
                                            win_reg[1], win_reg[0]);

    always_ff @(posedge clk)
    begin
        if (win_shift)
        begin
            win_reg[0] <= in_pix;
            for (int k = 1; k < 5; k++)
            begin
                win_reg[k] <= win_reg[k-1];
            end
        end
        if (en)
        begin
            s2_hval_reg <= hval;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_ctrl_reg <= '0;
        end
        else if (en)
        begin
            s2_ctrl_reg <= s1_ctrl;
        end
    end

endmodule

// ===== rtl/sbl_vpass.sv =====
// Four-line column store, vertical 1-2-4-2-1 filter and the output register.
module sbl_vpass import sbl_pkg::*; #(
    parameter int MAX_WIDTH = 1024
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         en,
    input  logic                         s1_hvalid,
    input  logic [$clog2(MAX_WIDTH)-1:0] s1_col,
    input  stage_ctrl_t                  s2_ctrl,
    input  pixel_t                       s2_hval,
    output logic                         out_valid_reg,
    output pixel_t                       out_pix_reg,
    output logic                         out_last_reg
);

    localparam int CW     = $clog2(MAX_WIDTH);
    localparam int PW     = $bits(pixel_t);
    localparam int LINE_W = LINE_TAPS * PW;

    logic [CW-1:0]     s2_col_reg;
    logic              fwd_reg;
    logic [LINE_W-1:0] fwd_data_reg;
    logic [LINE_W-1:0] rd_data;
    logic [LINE_W-1:0] taps;
    logic [LINE_W-1:0] wr_data;
    logic              rd_en, wr_en;
    pixel_t            tap_pix [LINE_TAPS];
    pixel_t            vval;

    assign rd_en = en && s1_hvalid;
    assign wr_en = en && s2_ctrl.hvalid;

    // With a one-pixel row the same column is read while it is being written.
    assign taps    = fwd_reg ? fwd_data_reg : rd_data;
    assign wr_data = {taps[(LINE_TAPS-1)*PW-1:0], s2_hval};

    always_comb
    begin
        for (int k = 0; k < LINE_TAPS; k++)
        begin
            tap_pix[k] = taps[k*PW +: PW];
        end
    end

    assign vval = s2_ctrl.v_edge ? tap_pix[1]
                                 : blur_pix(tap_pix[3], tap_pix[2], tap_pix[1],
                                            tap_pix[0], s2_hval);

    sbl_ram #(
        .WIDTH (LINE_W),
        .DEPTH (MAX_WIDTH)
    ) u_line_ram (
        .clk         (clk),
        .wr_en       (wr_en),
        .wr_addr     (s2_col_reg),
        .wr_data     (wr_data),
        .rd_en       (rd_en),
        .rd_addr     (s1_col),
        .rd_data_reg (rd_data)
    );

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s2_col_reg   <= s1_col;
            fwd_data_reg <= wr_data;
            out_pix_reg  <= vval;
            out_last_reg <= s2_ctrl.last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fwd_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            fwd_reg       <= s1_hvalid && s2_ctrl.hvalid && (s1_col == s2_col_reg);
            out_valid_reg <= s2_ctrl.emit;
        end
    end

endmodule
